// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL files; fhg_step.sv is the one that includes them.
// Each macro takes a label, the clock, the active-low reset and the checked terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must never be true
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("assertion failed: expression must never hold");

// cons must hold in the same cycle as ante
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/fhg_pkg.sv =====
`default_nettype none

package fhg_pkg;

    // Defaults for the top-level parameters
    localparam int PREFIX_BYTES_DEF    = 300;
    localparam int METADATA_OFFSET_DEF = 288;
    localparam int COUNT_BITS_DEF      = 24;

    // Metadata block
    localparam int          META_LEN    = 12;
    localparam int          META_IDX_W  = 4;
    localparam logic [31:0] META_MAGIC  = 32'h4D53_5441;
    localparam logic [7:0]  META_FORMAT = 8'd1;

    // Operation codes
    localparam logic [2:0] OP_BEGIN  = 3'd0;
    localparam logic [2:0] OP_DATA   = 3'd1;
    localparam logic [2:0] OP_CANCEL = 3'd2;
    localparam logic [2:0] OP_FINISH = 3'd3;
    localparam logic [2:0] OP_EOU    = 3'd4;

    // Update phases
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_WRITING  = 3'd1;
    localparam logic [2:0] PH_FAILED   = 3'd2;
    localparam logic [2:0] PH_COMPLETE = 3'd3;
    localparam logic [2:0] PH_REBOOT   = 3'd4;

    // Error codes
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_CANCELED    = 3'd1;
    localparam logic [2:0] ERR_OVERSIZE    = 3'd2;
    localparam logic [2:0] ERR_NO_META     = 3'd3;
    localparam logic [2:0] ERR_GENERATION  = 3'd4;
    localparam logic [2:0] ERR_VARIANT     = 3'd5;
    localparam logic [2:0] ERR_INCOMPLETE  = 3'd6;
    localparam logic [2:0] ERR_INTERRUPTED = 3'd7;

    // Configuration register indexes
    localparam logic [1:0] CFG_IMAGE_SIZE = 2'd0;
    localparam logic [1:0] CFG_EXP_GEN    = 2'd1;
    localparam logic [1:0] CFG_EXP_VAR    = 2'd2;

    // Metadata capture write from the step logic
    typedef struct packed {
        logic                  en;
        logic [META_IDX_W-1:0] idx;
        logic [7:0]            data;
    } t_meta_wr;

    // One result item
    typedef struct packed {
        logic        result_pending;
        logic [23:0] bytes_received;
        logic        abort_flash;
        logic        commit_prefix;
        logic [7:0]  forward_byte;
        logic        forward_valid;
        logic [2:0]  error_code;
        logic [2:0]  phase_now;
        logic        accepted;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/firmware_image_header_gate_unit.sv =====
// Firmware image header gate.
// Input stream (s side): one transaction per operation. tdata carries op in
// bits [2:0] and the image byte in [10:3]; tlast marks the end of a host
// write chunk and has no effect. Output stream (m side): exactly one result
// transaction per input transaction, in order.
// Configuration: image size, expected generation and expected variant are
// written through i_cfg_wr_en / i_cfg_idx / i_cfg_wdata; the user must do so
// only while the unit is idle, as the unit itself has no guard for it.
// An accepted transaction waits in the input register, is evaluated, lands
// in the result register when the pipe advances, then goes out on the m side.
// Throughput: one transaction per cycle while the receiver does not stall.
// The input and result registers advance together when the input register
// is full and the result register is empty or its content is being taken.
// Reset (synchronous, active low) returns the phase to idle, clears the flags,
// counter and error code, and loads the configuration defaults.
// When the receiver stalls, the result holds, the input register fills, and
// o_s_tready drops until the result is taken.
`default_nettype none

module firmware_image_header_gate_unit #(
    parameter int PREFIX_BYTES    = fhg_pkg::PREFIX_BYTES_DEF,
    parameter int METADATA_OFFSET = fhg_pkg::METADATA_OFFSET_DEF,
    parameter int COUNT_BITS      = fhg_pkg::COUNT_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [23:0] i_cfg_wdata,
    // input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,  // op[2:0], data_byte[10:3], zero pad
    input  wire logic        i_s_tlast,  // chunk_last
    // result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // accepted[0], phase_now[3:1], error_code[6:4], forward_valid[7],
    // forward_byte[15:8], commit_prefix[16], abort_flash[17],
    // bytes_received[41:18], result_pending[42], zero pad
    output logic [47:0]      o_m_tdata
);
    import fhg_pkg::*;

    logic        r_in_valid;
    logic [2:0]  r_op;
    logic [7:0]  r_byte;
    logic        adv;
    logic        s_fire;

    logic [23:0] r_image_size;
    logic [7:0]  r_exp_gen;
    logic [1:0]  r_exp_var;

    t_meta_wr    meta_wr;
    logic [2:0]  meta_code;
    t_result     res;
    t_result     r_res;
    logic        r_out_valid;

    // Advance when the input register is full and the result register is free
    assign adv        = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || adv;
    assign s_fire     = i_s_tvalid && o_s_tready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size <= 24'd0;
            r_exp_gen    <= 8'd1;
            r_exp_var    <= 2'd1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_SIZE: r_image_size <= i_cfg_wdata;
                CFG_EXP_GEN:    r_exp_gen    <= i_cfg_wdata[7:0];
                CFG_EXP_VAR:    r_exp_var    <= i_cfg_wdata[1:0];
                default: begin
                    // no register at this index
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_fire) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_op   <= i_s_tdata[2:0];
            r_byte <= i_s_tdata[10:3];
        end
    end

    fhg_step #(
        .PREFIX_BYTES   (PREFIX_BYTES),
        .METADATA_OFFSET(METADATA_OFFSET),
        .COUNT_BITS     (COUNT_BITS)
    ) u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_op        (r_op),
        .i_data_byte (r_byte),
        .i_image_size(r_image_size),
        .i_meta_code (meta_code),
        .o_meta_wr   (meta_wr),
        .o_res       (res)
    );

    fhg_meta u_meta (
        .i_clk    (i_clk),
        .i_wr     (meta_wr),
        .i_exp_gen(r_exp_gen),
        .i_exp_var(r_exp_var),
        .o_code   (meta_code)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_res};

    // tlast carries chunk boundaries only; it has no effect on the result
    logic unused_tlast;
    assign unused_tlast = i_s_tlast;

endmodule

`default_nettype wire

// ===== rtl/core/fhg_meta.sv =====
`default_nettype none

module fhg_meta (
    input  wire logic             i_clk,
    input  wire fhg_pkg::t_meta_wr i_wr,
    input  wire logic [7:0]       i_exp_gen,
    input  wire logic [1:0]       i_exp_var,
    output logic [2:0]            o_code
);
    import fhg_pkg::*;

    logic [7:0] r_meta [META_LEN];
    logic [7:0] eff    [META_LEN];
    logic [31:0] magic;

    // Capture one metadata byte per write
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_meta[i_wr.idx] <= i_wr.data;
        end
    end

    // Bypass: the byte written this cycle is seen by the check at once
    always_comb begin
        for (int k = 0; k < META_LEN; k++) begin
            eff[k] = (i_wr.en && i_wr.idx == META_IDX_W'(k)) ? i_wr.data : r_meta[k];
        end
    end

    assign magic = {eff[3], eff[2], eff[1], eff[0]};

    // Checks in priority order
    always_comb begin
        priority if (magic != META_MAGIC || eff[6] != META_FORMAT) begin
            o_code = ERR_NO_META;
        end else if (eff[7] != i_exp_gen) begin
            o_code = ERR_GENERATION;
        end else if (eff[8] != {6'd0, i_exp_var}) begin
            o_code = ERR_VARIANT;
        end else begin
            o_code = ERR_NONE;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/fhg_step.sv =====
`default_nettype none
`include "assert_macros.svh"

module fhg_step #(
    parameter int PREFIX_BYTES    = fhg_pkg::PREFIX_BYTES_DEF,
    parameter int METADATA_OFFSET = fhg_pkg::METADATA_OFFSET_DEF,
    parameter int COUNT_BITS      = fhg_pkg::COUNT_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  wire logic [2:0]        i_op,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic [23:0]       i_image_size,
    input  wire logic [2:0]        i_meta_code,
    output fhg_pkg::t_meta_wr      o_meta_wr,
    output fhg_pkg::t_result       o_res
);
    import fhg_pkg::*;

    localparam logic [31:0] PREFIX32 = 32'(PREFIX_BYTES);
    localparam logic [31:0] OFFSET32 = 32'(METADATA_OFFSET);
    localparam logic [31:0] METALEN32 = 32'(META_LEN);

    logic                  r_busy, n_busy;
    logic [2:0]            r_phase, n_phase;
    logic                  r_cancel, n_cancel;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [2:0]            r_err, n_err;
    logic                  r_pend, n_pend;

    logic [31:0] cnt32, cnt_p1, size32, meta_off, n_count32;
    logic        capture;
    logic        accepted, fwd_valid, commit, abort_p;
    logic [7:0]  fwd_byte;

    assign cnt32    = 32'(r_count);
    assign cnt_p1   = cnt32 + 32'd1;
    assign size32   = {8'd0, i_image_size};
    assign meta_off = cnt32 - OFFSET32;
    assign capture  = (cnt32 >= OFFSET32) && (meta_off < METALEN32);

    // Next state and result for the transaction at the head of the pipe
    always_comb begin
        n_busy    = r_busy;
        n_phase   = r_phase;
        n_cancel  = r_cancel;
        n_count   = r_count;
        n_err     = r_err;
        n_pend    = r_pend;
        accepted  = 1'b0;
        fwd_valid = 1'b0;
        fwd_byte  = 8'd0;
        commit    = 1'b0;
        abort_p   = 1'b0;
        o_meta_wr.en   = 1'b0;
        o_meta_wr.idx  = meta_off[META_IDX_W-1:0];
        o_meta_wr.data = i_data_byte;

        unique case (i_op)
            OP_BEGIN: begin
                if (!r_busy) begin
                    n_busy   = 1'b1;
                    n_cancel = 1'b0;
                    n_err    = ERR_NONE;
                    n_pend   = 1'b0;
                    n_count  = '0;
                    n_phase  = PH_WRITING;
                    accepted = 1'b1;
                end
            end
            OP_DATA: begin
                if (r_phase == PH_WRITING) begin
                    priority if (r_cancel) begin
                        n_err = ERR_CANCELED; n_phase = PH_FAILED;
                        n_pend = 1'b1; abort_p = 1'b1;
                    end else if (cnt32 >= size32) begin
                        n_err = ERR_OVERSIZE; n_phase = PH_FAILED;
                        n_pend = 1'b1; abort_p = 1'b1;
                    end else if (cnt32 < PREFIX32) begin
                        o_meta_wr.en = i_adv && capture;
                        // last prefix byte: check metadata
                        if (cnt_p1 >= PREFIX32 && i_meta_code != ERR_NONE) begin
                            n_err = i_meta_code; n_phase = PH_FAILED;
                            n_pend = 1'b1; abort_p = 1'b1;
                        end else begin
                            commit   = (cnt_p1 >= PREFIX32);
                            n_count  = r_count + COUNT_BITS'(1);
                            accepted = 1'b1;
                        end
                    end else begin
                        fwd_valid = 1'b1;
                        fwd_byte  = i_data_byte;
                        n_count   = r_count + COUNT_BITS'(1);
                        accepted  = 1'b1;
                    end
                end
            end
            OP_CANCEL: begin
                if (r_phase == PH_WRITING) begin
                    n_cancel = 1'b1;
                    accepted = 1'b1;
                end
            end
            OP_FINISH: begin
                priority if (r_cancel) begin
                    n_err = ERR_CANCELED; n_phase = PH_FAILED;
                    n_pend = 1'b1; abort_p = 1'b1;
                end else if (r_phase != PH_WRITING || cnt32 < PREFIX32) begin
                    n_err = ERR_INCOMPLETE; n_phase = PH_FAILED;
                    n_pend = 1'b1; abort_p = 1'b1;
                end else begin
                    n_phase  = PH_COMPLETE;
                    accepted = 1'b1;
                end
            end
            OP_EOU: begin
                if (r_phase == PH_COMPLETE || r_phase == PH_REBOOT) begin
                    n_phase  = PH_REBOOT;
                    accepted = 1'b1;
                end else begin
                    if (r_phase == PH_WRITING) begin
                        n_err   = r_cancel ? ERR_CANCELED : ERR_INTERRUPTED;
                        n_phase = PH_FAILED;
                        n_pend  = 1'b1;
                        abort_p = 1'b1;
                    end else begin
                        accepted = 1'b1;
                    end
                    n_busy = 1'b0;
                end
            end
            default: begin
                // unknown op: no effect
            end
        endcase
    end

    assign n_count32 = 32'(n_count);

    always_comb begin
        o_res.accepted       = accepted;
        o_res.phase_now      = n_phase;
        o_res.error_code     = n_err;
        o_res.forward_valid  = fwd_valid;
        o_res.forward_byte   = fwd_byte;
        o_res.commit_prefix  = commit;
        o_res.abort_flash    = abort_p;
        o_res.bytes_received = n_count32[23:0];
        o_res.result_pending = n_pend;
    end

    // Update state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_phase  <= PH_IDLE;
            r_cancel <= 1'b0;
            r_count  <= '0;
            r_err    <= ERR_NONE;
            r_pend   <= 1'b0;
        end else if (i_adv) begin
            r_busy   <= n_busy;
            r_phase  <= n_phase;
            r_cancel <= n_cancel;
            r_count  <= n_count;
            r_err    <= n_err;
            r_pend   <= n_pend;
        end
    end

    `ASSERT_NEVER(a_commit_abort_excl, i_clk, i_rst_n, o_res.commit_prefix && o_res.abort_flash)
    `ASSERT_NEXT(a_abort_to_failed, i_clk, i_rst_n, i_adv && abort_p, r_phase == PH_FAILED && r_pend)
    `ASSERT_IMPLY(a_fwd_accepted, i_clk, i_rst_n, fwd_valid, accepted && r_phase == PH_WRITING)

endmodule

`default_nettype wire

// ===== tb/sv/firmware_image_header_gate_unit_tb.sv =====
`timescale 1ns / 1ps

module firmware_image_header_gate_unit_tb;
    import fhg_pkg::*;

    localparam int PREFIX   = PREFIX_BYTES_DEF;
    localparam int META_OFF = METADATA_OFFSET_DEF;

    // Input transactions to send; the last session may run a little past this
    localparam int N_ITEMS = 1500;

    // Slowest legal run: ~1900 transactions, each behind the longest sender gap
    // and a chain of the longest receiver stalls, plus the path through the unit.
    localparam longint CYCLE_LIMIT = 6_000_000;

    // One stimulus row; chk marks rows whose status fields are typed in
    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic       last;
        logic       chk;
        logic       acc;
        logic [2:0] ph;
        logic [2:0] err;
    } t_stim_row;

    // Directed part, run at the reset configuration (image size 0)
    localparam int N_DIRECTED = 27;
    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        // refused and ignored operations while idle
        '{OP_DATA,   8'hFF, 1'b0, 1'b1, 1'b0, PH_IDLE,    ERR_NONE},
        '{OP_CANCEL, 8'h00, 1'b1, 1'b1, 1'b0, PH_IDLE,    ERR_NONE},
        // finish in idle fails as incomplete
        '{OP_FINISH, 8'h00, 1'b0, 1'b1, 1'b0, PH_FAILED,  ERR_INCOMPLETE},
        '{OP_EOU,    8'h00, 1'b0, 1'b1, 1'b1, PH_FAILED,  ERR_INCOMPLETE},
        // unknown operations
        '{3'd5,      8'hFF, 1'b1, 1'b1, 1'b0, PH_FAILED,  ERR_INCOMPLETE},
        '{3'd7,      8'h00, 1'b0, 1'b1, 1'b0, PH_FAILED,  ERR_INCOMPLETE},
        // begin, then begin while busy
        '{OP_BEGIN,  8'hFF, 1'b1, 1'b1, 1'b1, PH_WRITING, ERR_NONE},
        '{OP_BEGIN,  8'h00, 1'b0, 1'b1, 1'b0, PH_WRITING, ERR_NONE},
        // finish with too few bytes
        '{OP_FINISH, 8'h00, 1'b0, 1'b1, 1'b0, PH_FAILED,  ERR_INCOMPLETE},
        '{OP_EOU,    8'hFF, 1'b1, 1'b1, 1'b1, PH_FAILED,  ERR_INCOMPLETE},
        // data beyond a zero image size
        '{OP_BEGIN,  8'h00, 1'b0, 1'b1, 1'b1, PH_WRITING, ERR_NONE},
        '{OP_DATA,   8'h00, 1'b0, 1'b1, 1'b0, PH_FAILED,  ERR_OVERSIZE},
        '{OP_EOU,    8'h00, 1'b0, 1'b1, 1'b1, PH_FAILED,  ERR_OVERSIZE},
        // data with a cancel pending
        '{OP_BEGIN,  8'h00, 1'b0, 1'b1, 1'b1, PH_WRITING, ERR_NONE},
        '{OP_CANCEL, 8'h00, 1'b0, 1'b1, 1'b1, PH_WRITING, ERR_NONE},
        '{OP_DATA,   8'hAA, 1'b1, 1'b1, 1'b0, PH_FAILED,  ERR_CANCELED},
        '{OP_EOU,    8'h00, 1'b0, 1'b1, 1'b1, PH_FAILED,  ERR_CANCELED},
        // finish with a cancel pending
        '{OP_BEGIN,  8'h00, 1'b0, 1'b1, 1'b1, PH_WRITING, ERR_NONE},
        '{OP_CANCEL, 8'h55, 1'b1, 1'b1, 1'b1, PH_WRITING, ERR_NONE},
        '{OP_FINISH, 8'h00, 1'b0, 1'b1, 1'b0, PH_FAILED,  ERR_CANCELED},
        '{OP_EOU,    8'h00, 1'b0, 1'b1, 1'b1, PH_FAILED,  ERR_CANCELED},
        // end of upload while writing
        '{OP_BEGIN,  8'h00, 1'b0, 1'b1, 1'b1, PH_WRITING, ERR_NONE},
        '{OP_EOU,    8'h00, 1'b0, 1'b1, 1'b0, PH_FAILED,  ERR_INTERRUPTED},
        // end of upload while writing with a cancel pending
        '{OP_BEGIN,  8'h00, 1'b0, 1'b1, 1'b1, PH_WRITING, ERR_NONE},
        '{OP_CANCEL, 8'h00, 1'b0, 1'b1, 1'b1, PH_WRITING, ERR_NONE},
        '{OP_EOU,    8'h00, 1'b1, 1'b1, 1'b0, PH_FAILED,  ERR_CANCELED},
        '{3'd6,      8'h00, 1'b0, 1'b1, 1'b0, PH_FAILED,  ERR_CANCELED}
    };

    // DUT signals; the inputs are all known from time zero
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_idx   = CFG_IMAGE_SIZE;
    logic [23:0] i_cfg_wdata = '0;
    logic        i_s_tvalid  = 1'b0;
    logic [15:0] i_s_tdata   = '0;
    logic        i_s_tlast   = 1'b0;
    logic        i_m_tready  = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [47:0] o_m_tdata;

    firmware_image_header_gate_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // Gate model state and its copy of the registers
    logic        mdl_busy    = 1'b0;
    logic [2:0]  mdl_phase   = PH_IDLE;
    logic        mdl_cancel  = 1'b0;
    logic [23:0] mdl_count   = '0;
    logic [2:0]  mdl_err     = ERR_NONE;
    logic        mdl_pending = 1'b0;
    logic [7:0]  mdl_meta [META_LEN];
    logic [23:0] cfg_image_size = 24'd0;
    logic [7:0]  cfg_gen        = 8'd1;
    logic [1:0]  cfg_var        = 2'd1;

    t_result expected_status_q [$];
    int      err_count      = 0;
    int      sent_items     = 0;
    longint  cycle_cnt      = 0;
    bit      quiet          = 1'b0;
    int      rx_hold        = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("firmware_image_header_gate_unit_tb failed");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Receiver back-pressure
    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else if (quiet || $urandom_range(0, 99) < 65) begin
            i_m_tready <= 1'b1;
            rx_hold    <= $urandom_range(0, 7);
        end else begin
            i_m_tready <= 1'b0;
            rx_hold    <= idle_len();
        end
    end

    task automatic note_error(input string msg);
        err_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [23:0] got,
                               input logic [23:0] want);
        if (got !== want) note_error($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Gate model: applies one operation, returns the status it should report
    function automatic t_result gate_step(input logic [2:0] op, input logic [7:0] data_in);
        t_result    r;
        logic       fail;
        logic [2:0] code;
        int         slot;
        r    = '0;
        fail = 1'b0;
        code = ERR_NONE;
        case (op)
            OP_BEGIN: if (!mdl_busy) begin
                mdl_busy    = 1'b1;
                mdl_cancel  = 1'b0;
                mdl_err     = ERR_NONE;
                mdl_pending = 1'b0;
                mdl_count   = '0;
                mdl_phase   = PH_WRITING;
                r.accepted  = 1'b1;
            end
            OP_DATA: if (mdl_phase == PH_WRITING) begin
                if (mdl_cancel) begin
                    fail = 1'b1;
                    code = ERR_CANCELED;
                end else if (mdl_count >= cfg_image_size) begin
                    fail = 1'b1;
                    code = ERR_OVERSIZE;
                end else begin
                    if (int'(mdl_count) < PREFIX) begin
                        // capture the metadata window, verify on the last prefix byte
                        slot = int'(mdl_count) - META_OFF;
                        if (slot >= 0 && slot < META_LEN) mdl_meta[slot] = data_in;
                        if (int'(mdl_count) + 1 >= PREFIX) begin
                            if ({mdl_meta[3], mdl_meta[2], mdl_meta[1], mdl_meta[0]} != META_MAGIC
                                || mdl_meta[6] != META_FORMAT)
                                code = ERR_NO_META;
                            else if (mdl_meta[7] != cfg_gen)
                                code = ERR_GENERATION;
                            else if (mdl_meta[8] != {6'd0, cfg_var})
                                code = ERR_VARIANT;
                            fail            = (code != ERR_NONE);
                            r.commit_prefix = !fail;
                        end
                    end else begin
                        r.forward_valid = 1'b1;
                        r.forward_byte  = data_in;
                    end
                    if (!fail) begin
                        mdl_count  = mdl_count + 24'd1;
                        r.accepted = 1'b1;
                    end
                end
            end
            OP_CANCEL: if (mdl_phase == PH_WRITING) begin
                mdl_cancel = 1'b1;
                r.accepted = 1'b1;
            end
            OP_FINISH: begin
                if (mdl_cancel) begin
                    fail = 1'b1;
                    code = ERR_CANCELED;
                end else if (mdl_phase != PH_WRITING || int'(mdl_count) < PREFIX) begin
                    fail = 1'b1;
                    code = ERR_INCOMPLETE;
                end else begin
                    mdl_phase  = PH_COMPLETE;
                    r.accepted = 1'b1;
                end
            end
            OP_EOU: begin
                if (mdl_phase == PH_COMPLETE || mdl_phase == PH_REBOOT) begin
                    mdl_phase  = PH_REBOOT;
                    r.accepted = 1'b1;
                end else begin
                    if (mdl_phase == PH_WRITING) begin
                        fail = 1'b1;
                        code = mdl_cancel ? ERR_CANCELED : ERR_INTERRUPTED;
                    end else begin
                        r.accepted = 1'b1;
                    end
                    mdl_busy = 1'b0;
                end
            end
            default: ;
        endcase
        if (fail) begin
            mdl_err       = code;
            mdl_phase     = PH_FAILED;
            mdl_pending   = 1'b1;
            r.abort_flash = 1'b1;
        end
        r.phase_now      = mdl_phase;
        r.error_code     = mdl_err;
        r.bytes_received = mdl_count;
        r.result_pending = mdl_pending;
        return r;
    endfunction

    // Result monitor: every transaction out is matched against the oldest expectation
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_result'(o_m_tdata[42:0]);
            if (expected_status_q.size() == 0) begin
                note_error("result transaction with nothing outstanding");
            end else begin
                want = expected_status_q.pop_front();
                check_field("accepted",       got.accepted,       want.accepted);
                check_field("phase_now",      got.phase_now,      want.phase_now);
                check_field("error_code",     got.error_code,     want.error_code);
                check_field("forward_valid",  got.forward_valid,  want.forward_valid);
                check_field("forward_byte",   got.forward_byte,   want.forward_byte);
                check_field("commit_prefix",  got.commit_prefix,  want.commit_prefix);
                check_field("abort_flash",    got.abort_flash,    want.abort_flash);
                check_field("bytes_received", got.bytes_received, want.bytes_received);
                check_field("result_pending", got.result_pending, want.result_pending);
            end
        end
    end

    // Drive one input transaction; returns at the edge that accepted it
    task automatic send_txn(input t_stim_row row);
        t_result want;
        int      gap;
        gap = quiet ? 0 : idle_len();
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'd0, row.data, row.op};
        i_s_tlast  <= row.last;
        do @(posedge i_clk); while (!o_s_tready);
        want = gate_step(row.op, row.data);
        sent_items++;
        if (row.chk) begin
            want.accepted   = row.acc;
            want.phase_now  = row.ph;
            want.error_code = row.err;
        end
        expected_status_q.push_back(want);
    endtask

    task automatic send_op(input logic [2:0] op, input logic [7:0] data, input logic last);
        t_stim_row row;
        row      = '0;
        row.op   = op;
        row.data = data;
        row.last = last;
        send_txn(row);
    endtask

    // Hold the input idle and let everything outstanding drain
    task automatic flush_results();
        i_s_tvalid <= 1'b0;
        while (expected_status_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [23:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_IMAGE_SIZE: cfg_image_size = val;
            CFG_EXP_GEN:    cfg_gen        = val[7:0];
            CFG_EXP_VAR:    cfg_var        = val[1:0];
            default: ;
        endcase
    endtask

    // Full image: begin, bytes with proper metadata (one field sometimes broken), usually finish
    task automatic run_image();
        int         len;
        int         bad_k;
        int         k;
        logic [7:0] b;
        send_op(OP_BEGIN, 8'($urandom), 1'($urandom));
        if (int'(cfg_image_size) < PREFIX)
            len = int'(cfg_image_size) + $urandom_range(0, 2);
        else if (int'(cfg_image_size) <= PREFIX + 100)
            len = int'(cfg_image_size);
        else
            len = $urandom_range(PREFIX, PREFIX + 10);
        if ($urandom_range(0, 99) < 15) len = len + $urandom_range(1, 3);
        case ($urandom_range(0, 13))
            0, 1, 2, 3: bad_k = $urandom_range(0, 3);  // magic
            4:          bad_k = 6;                      // format
            5:          bad_k = 7;                      // generation
            6:          bad_k = 8;                      // variant
            default:    bad_k = -1;
        endcase
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            if (i >= META_OFF && i < META_OFF + META_LEN) begin
                k = i - META_OFF;
                if (k < 4)       b = META_MAGIC[8*k +: 8];
                else if (k == 6) b = META_FORMAT;
                else if (k == 7) b = cfg_gen;
                else if (k == 8) b = {6'd0, cfg_var};
                if (k == bad_k) b = b ^ 8'($urandom_range(1, 255));
            end
            send_op(OP_DATA, b, (i == len - 1) || ($urandom_range(0, 15) == 0));
        end
        if ($urandom_range(0, 9) != 0) send_op(OP_FINISH, 8'($urandom), 1'($urandom));
        repeat ($urandom_range(0, 2)) send_op(OP_EOU, 8'($urandom), 1'($urandom));
        repeat ($urandom_range(0, 2)) send_op(3'($urandom), 8'($urandom), 1'($urandom));
    endtask

    // Broken session: mostly data bytes with random operations mixed in
    task automatic run_noise();
        int n;
        if ($urandom_range(0, 3) != 0) send_op(OP_BEGIN, 8'($urandom), 1'($urandom));
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(250, 320) : $urandom_range(0, 30);
        repeat (n) begin
            if ($urandom_range(0, 99) < 85)
                send_op(OP_DATA, 8'($urandom), 1'($urandom));
            else
                send_op(3'($urandom), 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic run_session();
        quiet = ($urandom_range(0, 6) == 0);
        if ($urandom_range(0, 99) < 70) run_image();
        else                            run_noise();
        // complete and reboot-pending keep the unit busy; fail out, then release it
        if (mdl_phase == PH_COMPLETE || mdl_phase == PH_REBOOT)
            send_op(OP_FINISH, 8'($urandom), 1'($urandom));
        send_op(OP_EOU, 8'($urandom), 1'($urandom));
        quiet = 1'b0;
    endtask

    // Main sequence
    initial begin
        int          phase_idx;
        logic [23:0] size;
        logic [7:0]  gen;
        logic [1:0]  vrt;
        phase_idx = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) send_txn(DIRECTED[i]);

        // One session per configuration until enough transactions went in
        while (sent_items < N_ITEMS) begin
            flush_results();
            gen = 8'($urandom_range(1, 255));
            vrt = 2'($urandom_range(1, 3));
            case (phase_idx % 6)
                0: begin size = 24'd300;             gen = 8'd255; vrt = 2'd3; end
                1: begin size = 24'd299;             gen = 8'd1;   vrt = 2'd1; end
                2: size = 24'hFFFFFF;
                3: begin size = 24'($urandom_range(300, 316)); gen = 8'd1; vrt = 2'd2; end
                4: size = 24'($urandom_range(300, 316));
                default: size = (phase_idx == 5) ? 24'd0 : 24'($urandom_range(0, 299));
            endcase
            write_cfg(CFG_IMAGE_SIZE, size);
            write_cfg(CFG_EXP_GEN, {16'd0, gen});
            write_cfg(CFG_EXP_VAR, {22'd0, vrt});
            i_cfg_wr_en <= 1'b0;
            run_session();
            phase_idx++;
        end

        flush_results();
        if (err_count == 0)
            $display("firmware_image_header_gate_unit_tb passed");
        else
            $display("firmware_image_header_gate_unit_tb failed");
        $finish;
    end

endmodule
